@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL, sampled on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ant holds, cons must hold on that edge.
`define ASSERT_NOW(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: when ant holds, cons must hold on the following edge.
`define ASSERT_NEXT(label, ant, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/sce_pkg.sv @@
// Shared types and constants for the sorted common elements block.
package sce_pkg;

  // Default list capacity.
  localparam int DEPTH_DEFAULT = 32;

  // Most results emitted by one run.
  localparam int OUT_CAP = 32;

  // Width of one element.
  localparam int VALUE_W = 32;

  // Command codes carried in the op field.
  typedef enum logic [1:0] {
    OP_FIRST  = 2'd0,
    OP_SECOND = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

endpackage

@@ rtl/core/sorted_common_elements_top.sv @@
// Appends write straight into the list RAMs while idle; a run matches each first-list entry
// against the second list, insertion-sorts the matches and emits the results, all paced by
// the single read port of each RAM. New beats are taken again once the last result sits in
// the output register.
// Reset (synchronous, active high) clears the state, the counts, the overflow flags and m_tvalid.
`include "assert_macros.svh"

module sorted_common_elements_top #(
  parameter int DEPTH = sce_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] op, [33:2] value, [39:34] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value_res
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // [0] none_found, [1] overflow
);

  localparam int VW   = sce_pkg::VALUE_W;
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CapN = (DEPTH < sce_pkg::OUT_CAP) ? DEPTH : sce_pkg::OUT_CAP;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_MFETCH  = 11'b00000000010,
    ST_SRD     = 11'b00000000100,
    ST_SCMP    = 11'b00000001000,
    ST_SKEY_RD = 11'b00000010000,
    ST_SKEY    = 11'b00000100000,
    ST_SSHIFT  = 11'b00001000000,
    ST_PLACE   = 11'b00010000000,
    ST_ERD     = 11'b00100000000,
    ST_ELD     = 11'b01000000000,
    ST_ENONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // Input beat fields.
  logic [1:0]    in_op;
  logic [VW-1:0] in_value;
  logic          in_beat;

  // Counts and walk indexes.
  logic [CW-1:0] first_count, second_count;
  logic          dropped;
  logic          run_ovf;
  logic [CW-1:0] kept;
  logic [CW-1:0] mi, mj;
  logic [CW-1:0] si, sj, ek;
  logic signed [VW-1:0] key;

  // RAM ports.
  logic          f_we, s_we, f_re, s_re, ms_we, ms_re;
  logic [AW-1:0] ms_waddr, ms_raddr;
  logic [VW-1:0] ms_wdata;
  logic [VW-1:0] f_rd, s_rd, ms_rd;

  // Derived conditions.
  logic [CW-1:0] emit_n;
  logic          mj_at_end, ek_last, out_free, out_load;
  logic          out_last, out_none;
  logic          shift_go;

  assign in_op    = s_tdata[1:0];
  assign in_value = s_tdata[33:2];
  assign s_tready = (state == ST_IDLE);
  assign in_beat  = s_tvalid && s_tready;

  assign emit_n    = (kept > CW'(CapN)) ? CW'(CapN) : kept;
  assign mj_at_end = (({1'b0, mj} + (CW+1)'(1)) == {1'b0, second_count});
  assign ek_last   = (({1'b0, ek} + (CW+1)'(1)) == {1'b0, emit_n});
  assign out_free  = !m_tvalid || m_tready;
  assign shift_go  = ($signed(ms_rd) > key);

  // Appends write straight into the list RAMs while there is room.
  assign f_we = in_beat && (in_op == sce_pkg::OP_FIRST) && (first_count < CW'(DEPTH));
  assign s_we = in_beat && (in_op == sce_pkg::OP_SECOND) && (second_count < CW'(DEPTH));

  sce_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_first (
    .clk     (clk),
    .wr_en   (f_we),
    .wr_addr (first_count[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (f_re),
    .rd_addr (mi[AW-1:0]),
    .rd_data (f_rd)
  );

  sce_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_second (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (second_count[AW-1:0]),
    .wr_data (in_value),
    .rd_en   (s_re),
    .rd_addr (mj[AW-1:0]),
    .rd_data (s_rd)
  );

  sce_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_match (
    .clk     (clk),
    .wr_en   (ms_we),
    .wr_addr (ms_waddr),
    .wr_data (ms_wdata),
    .rd_en   (ms_re),
    .rd_addr (ms_raddr),
    .rd_data (ms_rd)
  );

  // Sequencer: RAM strobes and next state.
  always_comb begin
    state_next = state;
    f_re       = 1'b0;
    s_re       = 1'b0;
    ms_we      = 1'b0;
    ms_re      = 1'b0;
    ms_waddr   = kept[AW-1:0];
    ms_wdata   = f_rd;
    ms_raddr   = si[AW-1:0];
    out_load   = 1'b0;
    out_last   = 1'b0;
    out_none   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_beat && (in_op == sce_pkg::OP_RUN)) begin
          state_next = ST_MFETCH;
        end
      end
      ST_MFETCH: begin
        if ((mi == first_count) || (second_count == '0)) begin
          if (kept == '0) begin
            state_next = ST_ENONE;
          end else if (kept == CW'(1)) begin
            state_next = ST_ERD;
          end else begin
            state_next = ST_SKEY_RD;
          end
        end else begin
          f_re       = 1'b1;
          state_next = ST_SRD;
        end
      end
      ST_SRD: begin
        s_re       = 1'b1;
        state_next = ST_SCMP;
      end
      ST_SCMP: begin
        if (f_rd == s_rd) begin
          ms_we      = 1'b1;
          state_next = ST_MFETCH;
        end else if (mj_at_end) begin
          state_next = ST_MFETCH;
        end else begin
          state_next = ST_SRD;
        end
      end
      ST_SKEY_RD: begin
        if (si == kept) begin
          state_next = ST_ERD;
        end else begin
          ms_re      = 1'b1;
          state_next = ST_SKEY;
        end
      end
      ST_SKEY: begin
        ms_re      = 1'b1;
        ms_raddr   = AW'(sj - CW'(1));
        state_next = ST_SSHIFT;
      end
      ST_SSHIFT: begin
        if (shift_go) begin
          // Move the larger entry up one slot and fetch the next one down.
          ms_we    = 1'b1;
          ms_waddr = sj[AW-1:0];
          ms_wdata = ms_rd;
          if (sj == CW'(1)) begin
            state_next = ST_PLACE;
          end else begin
            ms_re    = 1'b1;
            ms_raddr = AW'(sj - CW'(2));
          end
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        ms_we      = 1'b1;
        ms_waddr   = sj[AW-1:0];
        ms_wdata   = key;
        state_next = ST_SKEY_RD;
      end
      ST_ERD: begin
        ms_re      = 1'b1;
        ms_raddr   = ek[AW-1:0];
        state_next = ST_ELD;
      end
      ST_ELD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = ek_last;
          state_next = ek_last ? ST_IDLE : ST_ERD;
        end
      end
      ST_ENONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          out_none   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers: state, counts, indexes and the overflow flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
      run_ovf      <= 1'b0;
      kept         <= '0;
      mi           <= '0;
      mj           <= '0;
      si           <= '0;
      sj           <= '0;
      ek           <= '0;
    end else begin
      state <= state_next;
      if (f_we) begin
        first_count <= first_count + CW'(1);
      end
      if (s_we) begin
        second_count <= second_count + CW'(1);
      end
      if (in_beat && !f_we && !s_we &&
          ((in_op == sce_pkg::OP_FIRST) || (in_op == sce_pkg::OP_SECOND))) begin
        dropped <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_beat && (in_op == sce_pkg::OP_RUN)) begin
            run_ovf <= dropped;
            dropped <= 1'b0;
            kept    <= '0;
            mi      <= '0;
          end
        end
        ST_MFETCH: begin
          mj <= '0;
          if ((mi == first_count) || (second_count == '0)) begin
            // Matching is done: the lists are empty again for new appends.
            first_count  <= '0;
            second_count <= '0;
            si           <= CW'(1);
            ek           <= '0;
          end
        end
        ST_SCMP: begin
          if (f_rd == s_rd) begin
            kept <= kept + CW'(1);
            mi   <= mi + CW'(1);
          end else if (mj_at_end) begin
            mi <= mi + CW'(1);
          end else begin
            mj <= mj + CW'(1);
          end
        end
        ST_SKEY_RD: begin
          sj <= si;
        end
        ST_SSHIFT: begin
          if (shift_go) begin
            sj <= sj - CW'(1);
          end
        end
        ST_PLACE: begin
          si <= si + CW'(1);
        end
        ST_ELD: begin
          if (out_free) begin
            ek <= ek + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Sort key holds the entry being inserted.
  always_ff @(posedge clk) begin
    if (state == ST_SKEY) begin
      key <= $signed(ms_rd);
    end
  end

  // Output register: valid is control, the payload loads with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= out_none ? '0 : ms_rd;
      m_tlast    <= out_last;
      m_tuser[0] <= out_none;
      m_tuser[1] <= run_ovf;
    end
  end

  // A none-found beat is always the single, zero-valued, final beat.
  `ASSERT_NOW(a_none_is_last, m_tvalid && m_tuser[0], m_tlast && (m_tdata == '0))
  // Matches never outnumber the first-list entries already walked.
  `ASSERT_NOW(a_kept_bound, (state == ST_MFETCH) || (state == ST_SRD) || (state == ST_SCMP), kept <= mi)
  // The insertion position stays inside the sorted prefix.
  `ASSERT_NOW(a_sort_pos, state == ST_SSHIFT, (sj >= CW'(1)) && (sj <= si) && (si < kept))
  // A run beat stops further input until the run has finished.
  `ASSERT_NEXT(a_run_blocks, in_beat && (in_op == sce_pkg::OP_RUN), !s_tready)

endmodule

@@ rtl/core/sce_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module sce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ verif/sorted_common_checker.sv @@
// Checker for the sorted common elements block: predicts results from accepted beats and compares.
`timescale 1ns / 1ps

module sorted_common_checker #(
  parameter int DEPTH = sce_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // [1:0] op, [33:2] value, [39:34] zero
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [31:0] value_res
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,   // [0] none_found, [1] overflow
  input  logic        check_end,
  output int          fail_count,
  output int          expected_left
);

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        none_found;
    logic        overflow;
  } common_result_t;

  // Predicted contents of the two lists and the dropped-append flag.
  logic signed [31:0] first_vals[$];
  logic signed [31:0] second_vals[$];
  logic               dropped;
  common_result_t     expected_results[$];
  logic               end_checked;

  initial begin
    fail_count    = 0;
    expected_left = 0;
    dropped       = 1'b0;
    end_checked   = 1'b0;
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Keep every first-list element found in the second list, sort ascending and queue results.
  task automatic predict_intersection();
    logic signed [31:0] kept[$];
    logic signed [31:0] key;
    common_result_t     res;
    int i;
    int j;
    int n;
    for (i = 0; i < first_vals.size(); i++) begin
      for (j = 0; j < second_vals.size(); j++) begin
        if (first_vals[i] == second_vals[j]) begin
          kept.push_back(first_vals[i]);
          break;
        end
      end
    end
    for (i = 1; i < kept.size(); i++) begin
      key = kept[i];
      j = i;
      while (j > 0 && kept[j-1] > key) begin
        kept[j] = kept[j-1];
        j--;
      end
      kept[j] = key;
    end
    if (kept.size() == 0) begin
      res.value      = '0;
      res.last       = 1'b1;
      res.none_found = 1'b1;
      res.overflow   = dropped;
      expected_results.push_back(res);
    end else begin
      n = (kept.size() > sce_pkg::OUT_CAP) ? sce_pkg::OUT_CAP : kept.size();
      for (i = 0; i < n; i++) begin
        res.value      = kept[i];
        res.last       = (i == n - 1);
        res.none_found = 1'b0;
        res.overflow   = dropped;
        expected_results.push_back(res);
      end
    end
    first_vals.delete();
    second_vals.delete();
    dropped = 1'b0;
  endtask

  // Apply one accepted input beat to the predicted state.
  task automatic apply_command(input logic [1:0] op, input logic [31:0] value);
    case (op)
      sce_pkg::OP_FIRST: begin
        if (first_vals.size() < DEPTH) first_vals.push_back(value);
        else dropped = 1'b1;
      end
      sce_pkg::OP_SECOND: begin
        if (second_vals.size() < DEPTH) second_vals.push_back(value);
        else dropped = 1'b1;
      end
      sce_pkg::OP_RUN: begin
        predict_intersection();
      end
      default: begin
      end
    endcase
  endtask

  // Compare one accepted output beat with the oldest prediction.
  task automatic compare_result();
    common_result_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("unexpected result value=%0d last=%0b user=%b",
                       $signed(m_tdata), m_tlast, m_tuser));
      return;
    end
    want = expected_results.pop_front();
    if (m_tdata !== want.value)
      report($sformatf("value_res got %0d want %0d", $signed(m_tdata), $signed(want.value)));
    if (m_tlast !== want.last)
      report($sformatf("last got %b want %b", m_tlast, want.last));
    if (m_tuser[0] !== want.none_found)
      report($sformatf("none_found got %b want %b", m_tuser[0], want.none_found));
    if (m_tuser[1] !== want.overflow)
      report($sformatf("overflow got %b want %b", m_tuser[1], want.overflow));
  endtask

  // Watch both channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      first_vals.delete();
      second_vals.delete();
      dropped = 1'b0;
    end else begin
      if (s_tvalid && s_tready) apply_command(s_tdata[1:0], s_tdata[33:2]);
      if (m_tvalid && m_tready) compare_result();
      if (check_end && !end_checked) begin
        end_checked = 1'b1;
        if (expected_results.size() != 0)
          report($sformatf("%0d expected results never arrived", expected_results.size()));
      end
    end
    expected_left = expected_results.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the sorted common elements block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 430;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [1:0] op, [33:2] value, [39:34] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [31:0] value_res
  logic        m_tlast;
  logic [1:0]  m_tuser;        // [0] none_found, [1] overflow
  logic        check_end = 1'b0;
  int          fail_count;
  int          expected_left;

  int items_sent = 0;
  int rx_beats = 0;
  int stall_cycles = 0;
  logic hold_now = 1'b0;
  logic hold_done = 1'b0;

  sorted_common_elements_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  sorted_common_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser),
    .check_end     (check_end),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // 8 ns clock.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Count output beats and start the one long receiver hold-off in the middle of a run.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      rx_beats++;
      if (!hold_done && rx_beats >= 40 && !m_tlast) begin
        hold_now  = 1'b1;
        hold_done = 1'b1;
      end
    end
  end

  // Receiver: random ready with a calm stretch and one long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_now) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_now = 1'b0;
      end
      m_tready <= (rx_beats >= 150 && rx_beats < 260) || ($urandom_range(0, 99) >= 19);
    end
  end

  // Watchdog: cycles in which no beat moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("sorted_common_elements_top test failed");
    $finish;
  end

  // Offer one beat, with random idle cycles before it, and wait until it is taken.
  task automatic send_beat(input logic [1:0] op, input logic [31:0] value);
    while (!(items_sent >= 120 && items_sent < 220) && $urandom_range(0, 99) < 19) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, value, op};
    do @(posedge clk); while (!s_tready);
    if (op != OP_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Stop offering until every predicted result has been taken.
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
  endtask

  // Element values lean on the signed extremes and small numbers.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  // Fill both lists from a shared pool so values overlap, interleaving appends, then run.
  task automatic run_sequence(input int n_first, input int n_second, input int pool_size);
    logic [31:0] pool[8];
    logic [31:0] value;
    int left_first;
    int left_second;
    left_first = n_first;
    left_second = n_second;
    for (int k = 0; k < 8; k++) pool[k] = pick_value();
    while (left_first + left_second > 0) begin
      if ($urandom_range(0, 9) == 0) value = pick_value();
      else value = pool[$urandom_range(0, pool_size - 1)];
      if (left_second == 0 || (left_first > 0 && $urandom_range(0, 1) == 0)) begin
        send_beat(sce_pkg::OP_FIRST, value);
        left_first--;
      end else begin
        send_beat(sce_pkg::OP_SECOND, value);
        left_second--;
      end
    end
    send_beat(sce_pkg::OP_RUN, $urandom());
  endtask

  // Main stimulus.
  initial begin
    int kind;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Run on two empty lists.
    send_beat(sce_pkg::OP_RUN, 32'h0);
    // Extremes, a repeated value in the first list and an ignored op code.
    send_beat(sce_pkg::OP_FIRST, 32'h7FFF_FFFF);
    send_beat(sce_pkg::OP_FIRST, 32'h8000_0000);
    send_beat(sce_pkg::OP_FIRST, 32'h0000_0000);
    send_beat(sce_pkg::OP_FIRST, 32'hFFFF_FFFF);
    send_beat(sce_pkg::OP_FIRST, 32'd5);
    send_beat(sce_pkg::OP_FIRST, 32'd5);
    send_beat(sce_pkg::OP_SECOND, 32'hFFFF_FFFF);
    send_beat(sce_pkg::OP_SECOND, 32'h8000_0000);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF);
    send_beat(sce_pkg::OP_SECOND, 32'h7FFF_FFFF);
    send_beat(sce_pkg::OP_SECOND, 32'd5);
    send_beat(sce_pkg::OP_RUN, 32'hFFFF_FFFF);
    // Nothing in common.
    send_beat(sce_pkg::OP_FIRST, 32'd1);
    send_beat(sce_pkg::OP_SECOND, 32'd2);
    send_beat(sce_pkg::OP_RUN, 32'h0);
    // Only the second list filled.
    send_beat(sce_pkg::OP_SECOND, 32'hAAAA_5555);
    send_beat(sce_pkg::OP_RUN, 32'h0);
    wait_for_drain();

    // Both lists overfilled from a small pool, so overflow is set.
    run_sequence(36, 34, 3);

    // Random sequences, mostly well formed.
    while (items_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        run_sequence($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(1, 8));
      end else if (kind < 78) begin
        run_sequence($urandom_range(30, 36), $urandom_range(30, 36), $urandom_range(1, 8));
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4)) send_beat(2'($urandom_range(0, 3)), $urandom());
      end else begin
        repeat ($urandom_range(1, 5)) send_beat(2'($urandom_range(0, 1)), pick_value());
      end
      if ($urandom_range(0, 99) < 10) wait_for_drain();
    end
    send_beat(sce_pkg::OP_RUN, $urandom());

    // Let everything drain, then give the verdict.
    s_tvalid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    check_end <= 1'b1;
    @(negedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("sorted_common_elements_top test passed");
    end else begin
      $display("sorted_common_elements_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sce_pkg.sv
rtl/core/sce_ram.sv
rtl/core/sorted_common_elements_top.sv
verif/sorted_common_checker.sv
verif/tb.sv
